// ===== design/sfwp_pkg.sv =====
`default_nettype none
package sfwp_pkg;

   localparam int FLASH_ADDR_BITS_DEFAULT = 23;
   localparam int MAX_CHUNK_BYTES_DEFAULT = 128;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int MODE_W  = 2;
   localparam int LANE_W  = 2;

   // reply codes
   localparam logic [BYTE_W-1:0] ACK_CODE = 8'h06;
   localparam logic [BYTE_W-1:0] NAK_CODE = 8'h15;

   // command codes
   localparam logic [BYTE_W-1:0] CMD_ARM    = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_DISARM = 8'h90;
   localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'hA0;

   // link modes
   localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARMED  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LENGTH = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DATA   = 2'd3;

   // result kinds
   localparam logic KIND_REPLY = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [LANE_W-1:0] LANE_LAST = 2'd3;

endpackage
`default_nettype wire

// ===== design/sfwp_parser.sv =====
`default_nettype none
module sfwp_parser #(
   parameter int FLASH_ADDR_BITS = sfwp_pkg::FLASH_ADDR_BITS_DEFAULT,
   parameter int MAX_CHUNK_BYTES = sfwp_pkg::MAX_CHUNK_BYTES_DEFAULT,
   parameter int RES_W           = 1 + 8 + FLASH_ADDR_BITS + 32 + 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire logic [sfwp_pkg::BYTE_W-1:0]  rx_byte,
   output logic      [RES_W-1:0]             res0,
   output logic      [RES_W-1:0]             res1,
   output logic      [1:0]                   res_count
);
   import sfwp_pkg::*;

   localparam int LEFT_W = $clog2(MAX_CHUNK_BYTES + 1);
   localparam logic [BYTE_W:0] LEN_MAX = (BYTE_W + 1)'(MAX_CHUNK_BYTES - 1);

   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic [LEFT_W-1:0]          left_ff, left_in, left_dec;
   logic [LANE_W-1:0]          lane_ff, lane_in;
   logic [23:0]                asm_ff, asm_in;
   logic [FLASH_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [WORD_W-1:0]          word;
   logic                       done;

   localparam logic [FLASH_ADDR_BITS-1:0] ZERO_ADDR = '0;

   function automatic logic [RES_W-1:0] pack_reply(input logic [BYTE_W-1:0] code);
      pack_reply = {KIND_REPLY, code, ZERO_ADDR, {WORD_W{1'b0}}, 1'b1};
   endfunction

   always_comb begin
      case (lane_ff)
         2'd0:    word = {24'b0, rx_byte};
         2'd1:    word = {16'b0, rx_byte, asm_ff[7:0]};
         2'd2:    word = {8'b0, rx_byte, asm_ff[15:0]};
         default: word = {rx_byte, asm_ff};
      endcase
   end

   assign left_dec = (left_ff != '0) ? LEFT_W'(left_ff - LEFT_W'(1)) : '0;
   assign done     = (left_dec == '0);

   always_comb begin
      mode_in   = mode_ff;
      left_in   = left_ff;
      lane_in   = lane_ff;
      asm_in    = asm_ff;
      addr_in   = addr_ff;
      res0      = pack_reply(ACK_CODE);
      res1      = pack_reply(ACK_CODE);
      res_count = 2'd0;
      case (mode_ff)
         MODE_LENGTH: begin
            res_count = 2'd1;
            if ({1'b0, rx_byte} > LEN_MAX) begin
               mode_in = MODE_IDLE;
               res0    = pack_reply(NAK_CODE);
            end else begin
               left_in = LEFT_W'(LEFT_W'(rx_byte) + LEFT_W'(1));
               lane_in = '0;
               asm_in  = '0;
               mode_in = MODE_DATA;
            end
         end
         MODE_DATA: begin
            left_in = left_dec;
            if (lane_ff == LANE_LAST || done) begin
               res_count = 2'd1;
               res0      = {KIND_WRITE, {BYTE_W{1'b0}}, addr_ff, word, !done};
               addr_in   = addr_ff + FLASH_ADDR_BITS'(4);
               lane_in   = '0;
               asm_in    = '0;
            end else begin
               asm_in  = word[23:0];
               lane_in = lane_ff + LANE_W'(1);
            end
            if (done) begin
               // padded word goes first, then the closing ACK
               mode_in   = MODE_ARMED;
               res_count = 2'd2;
            end
         end
         default: begin
            if (rx_byte == CMD_ARM) begin
               mode_in   = MODE_ARMED;
               res_count = 2'd1;
            end else if (rx_byte == CMD_DISARM) begin
               mode_in   = MODE_IDLE;
               res_count = 2'd1;
            end else if (rx_byte == CMD_WRITE && mode_ff == MODE_ARMED) begin
               mode_in   = MODE_LENGTH;
               res_count = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         left_ff <= '0;
         lane_ff <= '0;
         asm_ff  <= '0;
         addr_ff <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         left_ff <= left_in;
         lane_ff <= lane_in;
         asm_ff  <= asm_in;
         addr_ff <= addr_in;
      end
   end

   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DATA |-> left_ff != '0)
      else $error("data mode with no bytes left");

   a_lane_only_in_data: assert property (@(posedge clock) disable iff (reset)
      lane_ff != '0 |-> mode_ff == MODE_DATA)
      else $error("partial word outside data mode");

   a_lane_advance: assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == MODE_DATA && lane_ff != LANE_LAST && left_ff > LEFT_W'(1)
      |=> lane_ff == $past(lane_ff) + LANE_W'(1))
      else $error("byte lane did not advance");

endmodule
`default_nettype wire

// ===== design/serial_flash_write_protocol.sv =====
// Serial flash write protocol parser. Each received byte (req_ channel) is
// decoded and yields zero, one or two results (rsp_ channel):
// ACK/NAK reply bytes and 32-bit flash word writes. A byte is held in an
// input register and is processed once the four-entry result queue has room
// for two results, so with the result side free one byte is taken every
// cycle; a byte that completes a transfer yields a word write and an ACK and
// thus takes two places in the result stream. The result stream is the
// only limit on rate; rsp_last marks the final result of each byte. The
// write address advances by four per word and wraps at 2^FLASH_ADDR_BITS.
`default_nettype none
module serial_flash_write_protocol #(
   parameter int FLASH_ADDR_BITS = sfwp_pkg::FLASH_ADDR_BITS_DEFAULT,
   parameter int MAX_CHUNK_BYTES = sfwp_pkg::MAX_CHUNK_BYTES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sfwp_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_kind,
   output logic      [sfwp_pkg::BYTE_W-1:0]   rsp_reply_byte,
   output logic      [FLASH_ADDR_BITS-1:0]    rsp_flash_address,
   output logic      [sfwp_pkg::WORD_W-1:0]   rsp_flash_word,
   output logic                               rsp_last
);
   import sfwp_pkg::*;

   localparam int RES_W  = 1 + BYTE_W + FLASH_ADDR_BITS + WORD_W + 1;
   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              fire, pop;
   logic [RES_W-1:0]  res0, res1, head;
   logic [1:0]        res_count;

   logic [RES_W-1:0]  queue_ff [QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // process the held byte only when two result slots are free
   assign fire      = in_valid_ff && (count_ff <= CNT_W'(QDEPTH - 2));
   assign req_stall = in_valid_ff && !fire;
   assign pop       = rsp_valid && !rsp_stall;

   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sfwp_parser #(
      .FLASH_ADDR_BITS (FLASH_ADDR_BITS),
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
      .RES_W           (RES_W)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .rx_byte   (in_byte_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (fire) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(res_count);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      count_in = CNT_W'(count_ff + (fire ? CNT_W'(res_count) : CNT_W'(0))
                 - (pop ? CNT_W'(1) : CNT_W'(0)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (fire && res_count == 2'd2) begin
         queue_ff[PTR_W'(wr_ptr_ff + PTR_W'(1))] <= res1;
      end
   end

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);

   assign {rsp_kind, rsp_reply_byte, rsp_flash_address, rsp_flash_word, rsp_last} = head;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QDEPTH))
      else $error("result queue overflow");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> count_ff > CNT_W'(QDEPTH - 2))
      else $error("input stalled with room in result queue");

   a_fire_consumes: assert property (@(posedge clock) disable iff (reset)
      fire && !(req_valid && !req_stall) |=> !in_valid_ff)
      else $error("processed byte still held");

endmodule
`default_nettype wire

// ===== tb/serial_flash_write_protocol_checker.sv =====
`timescale 1ns / 1ps
module sfwp_response_checker #(
   parameter int ADDR_W    = sfwp_pkg::FLASH_ADDR_BITS_DEFAULT,
   parameter int MAX_CHUNK = sfwp_pkg::MAX_CHUNK_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [sfwp_pkg::BYTE_W-1:0]   req_rx_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_kind,
   input  logic [sfwp_pkg::BYTE_W-1:0]   rsp_reply_byte,
   input  logic [ADDR_W-1:0]             rsp_flash_address,
   input  logic [sfwp_pkg::WORD_W-1:0]   rsp_flash_word,
   input  logic                          rsp_last,
   output int                            mismatch_count,
   output int                            due_count,
   output int                            writes_checked,
   output int                            acks_checked,
   output int                            naks_checked
);
   import sfwp_pkg::*;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] reply;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] word;
      logic              last;
   } flash_result_type;

   flash_result_type due_responses[$];

   // shadow copy of the parser state
   logic [MODE_W-1:0] link_mode;
   int                bytes_left;
   logic [LANE_W-1:0] lane_index;
   logic [23:0]       word_assembly;
   logic [ADDR_W-1:0] write_address;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic flash_result_type make_reply(input logic [BYTE_W-1:0] code);
      flash_result_type r;
      r = '0;
      r.kind  = KIND_REPLY;
      r.reply = code;
      r.last  = 1'b1;
      return r;
   endfunction

   task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] word;
      logic              done;
      flash_result_type  wr;
      case (link_mode)
         MODE_LENGTH: begin
            if (b > MAX_CHUNK - 1) begin
               link_mode = MODE_IDLE;
               due_responses.push_back(make_reply(NAK_CODE));
            end else begin
               bytes_left    = int'(b) + 1;
               lane_index    = '0;
               word_assembly = '0;
               link_mode     = MODE_DATA;
               due_responses.push_back(make_reply(ACK_CODE));
            end
         end
         MODE_DATA: begin
            word = {8'h00, word_assembly} | (WORD_W'(b) << (lane_index * 8));
            if (bytes_left != 0) bytes_left = bytes_left - 1;
            done = (bytes_left == 0);
            if (lane_index == LANE_LAST || done) begin
               wr       = '0;
               wr.kind  = KIND_WRITE;
               wr.addr  = write_address;
               wr.word  = word;
               wr.last  = !done;
               due_responses.push_back(wr);
               write_address = write_address + ADDR_W'(4);
               lane_index    = '0;
               word_assembly = '0;
            end else begin
               word_assembly = word[23:0];
               lane_index    = lane_index + LANE_W'(1);
            end
            if (done) begin
               link_mode = MODE_ARMED;
               due_responses.push_back(make_reply(ACK_CODE));
            end
         end
         default: begin
            if (b == CMD_ARM) begin
               link_mode = MODE_ARMED;
               due_responses.push_back(make_reply(ACK_CODE));
            end else if (b == CMD_DISARM) begin
               link_mode = MODE_IDLE;
               due_responses.push_back(make_reply(ACK_CODE));
            end else if (b == CMD_WRITE && link_mode == MODE_ARMED) begin
               link_mode = MODE_LENGTH;
               due_responses.push_back(make_reply(ACK_CODE));
            end
         end
      endcase
   endtask

   task automatic check_response();
      flash_result_type want;
      if (due_responses.size() == 0) begin
         report_mismatch($sformatf(
            "result with nothing due: kind %0d reply %02h addr %06h word %08h",
            rsp_kind, rsp_reply_byte, rsp_flash_address, rsp_flash_word));
         return;
      end
      want = due_responses.pop_front();
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
      if (rsp_reply_byte !== want.reply)
         report_mismatch($sformatf("reply_byte %02h, want %02h", rsp_reply_byte, want.reply));
      if (rsp_flash_address !== want.addr)
         report_mismatch($sformatf("flash_address %06h, want %06h",
                                   rsp_flash_address, want.addr));
      if (rsp_flash_word !== want.word)
         report_mismatch($sformatf("flash_word %08h, want %08h", rsp_flash_word, want.word));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0d, want %0d", rsp_last, want.last));
      if (want.kind == KIND_WRITE) writes_checked++;
      else if (want.reply == NAK_CODE) naks_checked++;
      else acks_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         link_mode      = MODE_IDLE;
         bytes_left     = 0;
         lane_index     = '0;
         word_assembly  = '0;
         write_address  = '0;
         mismatch_count = 0;
         writes_checked = 0;
         acks_checked   = 0;
         naks_checked   = 0;
         due_responses.delete();
      end else begin
         if (req_valid && !req_stall) decode_rx_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) check_response();
      end
      due_count = due_responses.size();
   end

endmodule

// ===== tb/serial_flash_write_protocol_tb.sv =====
`timescale 1ns / 1ps
module serial_flash_write_protocol_tb;
   import sfwp_pkg::*;

   localparam int ADDR_W      = FLASH_ADDR_BITS_DEFAULT;
   localparam int MAX_CHUNK   = MAX_CHUNK_BYTES_DEFAULT;
   localparam int ITEM_TARGET = 1575;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 16;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_kind;
   logic [BYTE_W-1:0]   rsp_reply_byte;
   logic [ADDR_W-1:0]   rsp_flash_address;
   logic [WORD_W-1:0]   rsp_flash_word;
   logic                rsp_last;

   int mismatch_count;
   int due_count;
   int writes_checked;
   int acks_checked;
   int naks_checked;

   int  cycle_count = 0;
   int  bytes_sent  = 0;
   bit  req_calm    = 0;
   bit  rsp_calm    = 0;
   bit  link_armed  = 0;

   serial_flash_write_protocol #(
      .FLASH_ADDR_BITS(ADDR_W),
      .MAX_CHUNK_BYTES(MAX_CHUNK)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_reply_byte   (rsp_reply_byte),
      .rsp_flash_address(rsp_flash_address),
      .rsp_flash_word   (rsp_flash_word),
      .rsp_last         (rsp_last)
   );

   sfwp_response_checker #(
      .ADDR_W   (ADDR_W),
      .MAX_CHUNK(MAX_CHUNK)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_reply_byte   (rsp_reply_byte),
      .rsp_flash_address(rsp_flash_address),
      .rsp_flash_word   (rsp_flash_word),
      .rsp_last         (rsp_last),
      .mismatch_count   (mismatch_count),
      .due_count        (due_count),
      .writes_checked   (writes_checked),
      .acks_checked     (acks_checked),
      .naks_checked     (naks_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, due_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stall before each transfer, with calm stretches
   initial begin : rsp_side
      int wait_cycles;
      int results_taken;
      rsp_stall = 1'b0;
      results_taken = 0;
      forever begin
         if (results_taken % 48 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         wait_cycles = rsp_calm ? 0 : $urandom_range(0, 11);
         rsp_stall <= (wait_cycles > 0);
         if (wait_cycles > 0) begin
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         results_taken++;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (bytes_sent % 64 == 0) req_calm = ($urandom_range(0, 3) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // arm if needed or at random, open a write, then send len_code+1 random data bytes
   task automatic send_chunk(input int len_code);
      if (!link_armed || $urandom_range(0, 7) == 0) send_byte(CMD_ARM);
      link_armed = 1;
      send_byte(CMD_WRITE);
      send_byte(BYTE_W'(len_code));
      for (int i = 0; i <= len_code; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
   endtask

   initial begin : stimulus
      int          pick;
      int          len_code;
      logic [7:0]  b;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored bytes, idle write, NAK, commands as data, extremes
      send_byte(8'h00);
      send_byte(CMD_WRITE);
      send_byte(CMD_DISARM);
      send_byte(CMD_ARM);
      send_byte(8'h55);
      send_byte(CMD_WRITE);
      send_byte(8'h80);
      send_byte(CMD_WRITE);
      send_byte(CMD_ARM);
      send_byte(CMD_WRITE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CMD_WRITE);
      send_byte(8'h04);
      send_byte(CMD_ARM);
      send_byte(CMD_DISARM);
      send_byte(CMD_WRITE);
      send_byte(ACK_CODE);
      send_byte(NAK_CODE);
      send_byte(CMD_WRITE);
      send_byte(8'hFF);
      send_byte(CMD_ARM);
      send_byte(CMD_DISARM);
      link_armed = 0;

      while (bytes_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            case ($urandom_range(0, 15))
               0:       len_code = MAX_CHUNK - 1;
               1:       len_code = $urandom_range(16, MAX_CHUNK - 1);
               default: len_code = $urandom_range(0, 15);
            endcase
            send_chunk(len_code);
         end else if (pick == 7) begin
            // bad length drops back to idle
            if (!link_armed) send_byte(CMD_ARM);
            send_byte(CMD_WRITE);
            send_byte(BYTE_W'($urandom_range(MAX_CHUNK, 255)));
            link_armed = 0;
         end else if (pick == 8) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == CMD_WRITE) b = 8'h00;
            if (b == CMD_ARM) link_armed = 1;
            if (b == CMD_DISARM) link_armed = 0;
            send_byte(b);
         end else begin
            link_armed = 1'($urandom_range(0, 1));
            send_byte(link_armed ? CMD_ARM : CMD_DISARM);
         end
      end
      req_valid <= 1'b0;

      while (due_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d bytes in %0d cycles", bytes_sent, cycle_count);
      $display("checked %0d word writes, %0d ACK and %0d NAK replies",
               writes_checked, acks_checked, naks_checked);
      if (mismatch_count == 0 && due_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatch_count, due_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
